// ----- rtl/kmcc_pkg.sv -----
// Shared types, constants and helpers for the k-way merge and coalesce block.
`default_nettype none
package kmcc_pkg;

  localparam int unsigned MAX_STREAMS = 16;
  localparam int unsigned SIDX_W      = $clog2(MAX_STREAMS);
  localparam int unsigned FILL_W      = $clog2(MAX_STREAMS + 1);
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CNT_W       = 32;
  localparam logic [CNT_W-1:0] SUM_MAX = '1;

  typedef struct packed {
    logic        stream_ended;
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] count;
  } in_item_t;

  typedef struct packed {
    logic        record_valid;
    logic [15:0] out_row;
    logic [15:0] out_col;
    logic [31:0] out_count;
    logic [3:0]  want_stream;
    logic        finished;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_REMOVE,
    ST_EMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic prime_step;
    logic finish;
    logic scan_start;
    logic scan_step;
    logic remove;
    logic load_out;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic priming;
    logic prime_more;
    logic heap_empty;
    logic heap_single;
    logic scan_last;
    logic out_free;
  } dp_status_t;

  // Clamp the register value into the legal stream count range.
  function automatic logic [FILL_W-1:0] active_streams(input logic [CFG_W-1:0] cfg);
    logic [FILL_W-1:0] n;
    if (cfg == '0) begin
      n = FILL_W'(1);
    end else if (32'(cfg) > MAX_STREAMS) begin
      n = FILL_W'(MAX_STREAMS);
    end else begin
      n = FILL_W'(cfg);
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/kmcc_ctrl.sv -----
// Sequencing state machine for the merge: accept, decide, scan, remove, emit.
`default_nettype none
module kmcc_ctrl
  import kmcc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output ctl_cmd_t        cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = rst || (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !rst) begin
          cmd.accept = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (status.priming && status.prime_more) begin
          cmd.prime_step = 1'b1;
          state_next     = ST_EMIT;
        end else if (status.heap_empty) begin
          cmd.finish = 1'b1;
          state_next = ST_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = status.heap_single ? ST_REMOVE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) begin
          state_next = ST_REMOVE;
        end
      end
      ST_REMOVE: begin
        cmd.remove = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/kmcc_dpath.sv -----
// Head table, candidate list, pending record and output register of the merge.
`default_nettype none
module kmcc_dpath
  import kmcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire in_item_t         in_data,
  input  wire ctl_cmd_t         cmd,
  output dp_status_t            status,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  logic [KEY_W-1:0]  head_keys   [MAX_STREAMS];
  logic [CNT_W-1:0]  head_counts [MAX_STREAMS];
  logic [SIDX_W-1:0] heap_order  [MAX_STREAMS];

  logic [CFG_W-1:0]  streams_in_use;
  logic [FILL_W-1:0] heap_fill;
  logic [FILL_W-1:0] priming_index;
  logic              merging;
  logic [SIDX_W-1:0] requested_stream;
  logic [KEY_W-1:0]  pending_key;
  logic [CNT_W-1:0]  pending_sum;
  logic              pending_valid;

  logic [SIDX_W-1:0] scan_idx;
  logic [SIDX_W-1:0] best_pos;
  logic [SIDX_W-1:0] best_stream;
  logic [KEY_W-1:0]  best_key;
  out_item_t         result;
  out_item_t         result_next;

  logic [FILL_W-1:0] n_active;
  logic [SIDX_W-1:0] last_pos;
  logic [SIDX_W-1:0] ord_addr;
  logic [SIDX_W-1:0] ord_rd;
  logic [KEY_W-1:0]  key_rd;
  logic [CNT_W-1:0]  best_cnt;
  logic              better;
  logic              coalesce;
  logic [CNT_W:0]    sum_wide;
  logic [CNT_W-1:0]  sum_sat;
  logic [FILL_W:0]   prime_inc;

  assign n_active  = active_streams(streams_in_use);
  assign last_pos  = SIDX_W'(heap_fill - FILL_W'(1));
  assign prime_inc = {1'b0, priming_index} + (FILL_W+1)'(1);

  // One read port on the candidate list: tail on removal, slot 0 at scan start, scan index otherwise.
  always_comb begin
    if (cmd.remove) begin
      ord_addr = last_pos;
    end else if (cmd.scan_start) begin
      ord_addr = '0;
    end else begin
      ord_addr = scan_idx;
    end
  end

  assign ord_rd   = heap_order[ord_addr];
  assign key_rd   = head_keys[ord_rd];
  assign best_cnt = head_counts[best_stream];
  assign better   = (key_rd < best_key) || ((key_rd == best_key) && (ord_rd < best_stream));
  assign coalesce = pending_valid && (best_key == pending_key);
  assign sum_wide = {1'b0, pending_sum} + {1'b0, best_cnt};
  assign sum_sat  = sum_wide[CNT_W] ? SUM_MAX : sum_wide[CNT_W-1:0];

  always_comb begin
    status.priming     = !merging;
    status.prime_more  = prime_inc < {1'b0, n_active};
    status.heap_empty  = (heap_fill == '0);
    status.heap_single = (heap_fill == FILL_W'(1));
    status.scan_last   = ({1'b0, scan_idx} == FILL_W'(last_pos));
    status.out_free    = !out_valid || !out_stall;
  end

  // Stage the result of the step being decided.
  always_comb begin
    result_next = result;
    if (cmd.prime_step) begin
      result_next             = '0;
      result_next.want_stream = prime_inc[SIDX_W-1:0];
    end else if (cmd.finish) begin
      result_next          = '0;
      result_next.finished = 1'b1;
      if (pending_valid) begin
        result_next.record_valid = 1'b1;
        result_next.out_row      = pending_key[31:16];
        result_next.out_col      = pending_key[15:0];
        result_next.out_count    = pending_sum;
      end
    end else if (cmd.remove) begin
      result_next             = '0;
      result_next.want_stream = best_stream;
      if (pending_valid && !coalesce) begin
        result_next.record_valid = 1'b1;
        result_next.out_row      = pending_key[31:16];
        result_next.out_col      = pending_key[15:0];
        result_next.out_count    = pending_sum;
      end
    end
  end

  // Head table and candidate list: undefined until written, no reset.
  always_ff @(posedge clk) begin
    if (cmd.accept && !in_data.stream_ended && !heap_fill[FILL_W-1]) begin
      head_keys[requested_stream]          <= {in_data.row, in_data.col};
      head_counts[requested_stream]        <= in_data.count;
      heap_order[heap_fill[SIDX_W-1:0]]    <= requested_stream;
    end
    if (cmd.remove) begin
      heap_order[best_pos] <= ord_rd;
    end
  end

  // Scan registers and the staged result.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx    <= SIDX_W'(1);
      best_pos    <= '0;
      best_stream <= ord_rd;
      best_key    <= key_rd;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + SIDX_W'(1);
      if (better) begin
        best_pos    <= scan_idx;
        best_stream <= ord_rd;
        best_key    <= key_rd;
      end
    end

    result <= result_next;

    if (cmd.load_out) begin
      out_data <= result;
    end
  end

  // Control state of the merge.
  always_ff @(posedge clk) begin
    if (rst) begin
      streams_in_use   <= CFG_W'(MAX_STREAMS);
      heap_fill        <= '0;
      priming_index    <= '0;
      merging          <= 1'b0;
      requested_stream <= '0;
      pending_key      <= '0;
      pending_sum      <= '0;
      pending_valid    <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        streams_in_use <= cfg_data;
      end

      if (cmd.accept && !in_data.stream_ended && !heap_fill[FILL_W-1]) begin
        heap_fill <= heap_fill + FILL_W'(1);
      end else if (cmd.remove) begin
        heap_fill <= heap_fill - FILL_W'(1);
      end

      if (cmd.prime_step) begin
        priming_index    <= prime_inc[FILL_W-1:0];
        requested_stream <= prime_inc[SIDX_W-1:0];
      end else if (cmd.scan_start && !merging) begin
        priming_index <= prime_inc[FILL_W-1:0];
        merging       <= 1'b1;
      end else if (cmd.finish) begin
        priming_index    <= '0;
        merging          <= 1'b0;
        pending_valid    <= 1'b0;
        pending_key      <= '0;
        pending_sum      <= '0;
        requested_stream <= '0;
      end else if (cmd.remove) begin
        requested_stream <= best_stream;
        pending_valid    <= 1'b1;
        if (coalesce) begin
          pending_sum <= sum_sat;
        end else begin
          pending_key <= best_key;
          pending_sum <= best_cnt;
        end
      end

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kway_merge_count_coalesce_core.sv -----
// Top level of the k-way merge with duplicate-key count coalescing.
//
// Usage: the block drives want_stream in every result; the source answers
// with one input transaction for that stream (stream 0 after reset and after
// finished). The first results prime the candidate set by asking for streams
// 1..n-1; each later one pops the smallest key (ties to the lower stream),
// emits the pending record when the key changes or sums into it (saturating
// at all ones), and names the popped stream. stream_ended drops a stream.
// When no candidate is left, the pending record is flushed with finished set.
// Every input transaction yields exactly one output transaction.
// Priming and flush results are staged in the decide step and loaded into
// the output register in the emit step; a merge result first scans the live
// candidates in the head table, one entry per cycle, then removes the best
// one before the emit step. The input reopens in the cycle after the result
// is loaded. The output register holds a result while out_stall
// is high; the next input can be taken meanwhile, and only a second
// result waits. Reset (rst, synchronous) empties the candidate set, drops
// the pending record, restarts priming and sets streams_in_use to 16.
// cfg_ready is always high; write the register only while idle.
`default_nettype none
module kway_merge_count_coalesce_core
  import kmcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  kmcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  kmcc_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/kmcc_checker.sv -----
// Port-level checks for the merge core, bound to the top level.
`default_nettype none
module kmcc_checker
  import kmcc_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready,
  input wire logic [CFG_W-1:0] cfg_data,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire in_item_t         in_data,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire out_item_t        out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A finished result names stream 0.
  a_finish_want: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.finished |-> out_data.want_stream == '0)
    else $error("finished result names a stream");

  // A result without a record carries zero record fields.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.record_valid |->
      out_data.out_row == '0 && out_data.out_col == '0 && out_data.out_count == '0)
    else $error("record fields set without a record");

  // One item at a time: input closes right after a transaction.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second input taken while busy");

endmodule

bind kway_merge_count_coalesce_core kmcc_checker u_kmcc_checker (.*);
`default_nettype wire
